// ===== src/klx_pkg.sv =====
// Shared constants, token kinds and keyword tables for the keyword/punctuation lexer.
`timescale 1ns / 1ps
`default_nettype none

package klx_pkg;

  // Fixed field widths of a token
  localparam int KindW   = 4;
  localparam int LenW    = 4;
  localparam int TokNumW = 32;

  // Default counter widths and queue depth
  localparam int PositionWidthDef = 32;
  localparam int LineWidthDef     = 24;
  localparam int ColumnWidthDef   = 16;
  localparam int QueueDepthDef    = 4;

  localparam int NumKw = 7;

  typedef enum logic [KindW-1:0] {
    KIND_CONTINUE  = 4'd0,
    KIND_FOR       = 4'd1,
    KIND_DO        = 4'd2,
    KIND_WHILE     = 4'd3,
    KIND_NAMESPACE = 4'd4,
    KIND_STRUCT    = 4'd5,
    KIND_CLASS     = 4'd6,
    KIND_LPAREN    = 4'd7,
    KIND_RPAREN    = 4'd8,
    KIND_LBRACE    = 4'd9,
    KIND_RBRACE    = 4'd10,
    KIND_SEMI      = 4'd11,
    KIND_COLON     = 4'd12
  } kind_e;

  // Packed width of one token record
  function automatic int tok_bits(input int pos_w, input int line_w, input int col_w);
    return KindW + pos_w + LenW + line_w + col_w + TokNumW + 1;
  endfunction

  // Length of a keyword in bytes
  function automatic logic [LenW-1:0] kw_len(input kind_e k);
    logic [LenW-1:0] r;
    case (k)
      KIND_CONTINUE:  r = 4'd8;
      KIND_FOR:       r = 4'd3;
      KIND_DO:        r = 4'd2;
      KIND_WHILE:     r = 4'd5;
      KIND_NAMESPACE: r = 4'd9;
      KIND_STRUCT:    r = 4'd6;
      KIND_CLASS:     r = 4'd5;
      default:        r = 4'd0;
    endcase
    return r;
  endfunction

  // Byte idx of a keyword, zero past its end
  function automatic logic [7:0] kw_char(input kind_e k, input logic [LenW-1:0] idx);
    logic [71:0] s;
    logic [7:0]  r;
    case (k)
      KIND_CONTINUE:  s = {"continue", 8'h00};
      KIND_FOR:       s = {"for", 48'h0};
      KIND_DO:        s = {"do", 56'h0};
      KIND_WHILE:     s = {"while", 32'h0};
      KIND_NAMESPACE: s = "namespace";
      KIND_STRUCT:    s = {"struct", 24'h0};
      KIND_CLASS:     s = {"class", 32'h0};
      default:        s = '0;
    endcase
    r = 8'h00;
    if (idx < 4'd9) r = s[8*(8-int'(idx)) +: 8];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/klx_front.sv =====
// Scanner front end: byte classification, scan state and token generation.
`timescale 1ns / 1ps
`default_nettype none

module klx_front import klx_pkg::*; #(
  parameter int POSITION_WIDTH = PositionWidthDef,
  parameter int LINE_WIDTH     = LineWidthDef,
  parameter int COLUMN_WIDTH   = ColumnWidthDef,
  localparam int TokW          = tok_bits(POSITION_WIDTH, LINE_WIDTH, COLUMN_WIDTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        ch_i,
  input  wire logic              last_i,
  output logic                   push_o,
  output logic [2*TokW:0]        push_data_o
);

  typedef enum logic [8:0] {
    M_IDLE       = 9'b000000001,
    M_WORD       = 9'b000000010,
    M_WORD_L     = 9'b000000100,
    M_SLASH      = 9'b000001000,
    M_BLOCK      = 9'b000010000,
    M_BLOCK_STAR = 9'b000100000,
    M_LINE       = 9'b001000000,
    M_PREPROC    = 9'b010000000,
    M_STRING     = 9'b100000000
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic [POSITION_WIDTH-1:0] pos;
    logic [LenW-1:0]           len;
    logic [LINE_WIDTH-1:0]     line;
    logic [COLUMN_WIDTH-1:0]   col;
    logic [TokNumW-1:0]        num;
    logic                      eob;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  mode_e                     mode_q, mode_d;
  logic                      qs_q, qs_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [NumKw-1:0]          hits_q, hits_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [LINE_WIDTH-1:0]     line_q, line_d;
  logic [COLUMN_WIDTH-1:0]   col_q, col_d;
  logic [POSITION_WIDTH-1:0] wpos_q, wpos_d;
  logic [LINE_WIDTH-1:0]     wline_q, wline_d;
  logic [COLUMN_WIDTH-1:0]   wcol_q, wcol_d;
  logic                      halt_q, halt_d;
  logic [TokNumW-1:0]        cnt_q, cnt_d;

  logic is_ws, is_idc, is_quote, is_nl;
  logic run_idle, kw_a, flush;
  logic [LenW-1:0]  add_base;
  logic [NumKw-1:0] add_match;
  logic [LenW-1:0]  sel_len;
  logic [NumKw-1:0] sel_hits;
  logic             kw_v, punct_v;
  kind_e            kw_kind, punct_kind;
  logic [TokNumW-1:0] cnt1, cnt2;
  tok_t   kw_tok, p_tok;
  entry_t ent;

  always_comb begin
    is_ws    = ch_i inside {8'h20, [8'h09:8'h0D]};
    is_idc   = ch_i inside {["A":"Z"], ["a":"z"], ["0":"9"], "_"};
    is_quote = (ch_i == "\"") || (ch_i == "'");
    is_nl    = (ch_i == 8'h0A);
  end

  // Advance the running word by one byte: from scratch outside a word
  always_comb begin
    add_base = (mode_q == M_WORD || mode_q == M_WORD_L) ? len_q : '0;
    for (int k = 0; k < NumKw; k++) begin
      add_match[k] = (add_base < kw_len(kind_e'(KindW'(k)))) &&
                     (kw_char(kind_e'(KindW'(k)), add_base) == ch_i);
    end
  end

  always_comb begin
    mode_d     = mode_q;
    qs_d       = qs_q;
    len_d      = len_q;
    hits_d     = hits_q;
    wpos_d     = wpos_q;
    wline_d    = wline_q;
    wcol_d     = wcol_q;
    halt_d     = halt_q;
    run_idle   = 1'b0;
    kw_a       = 1'b0;
    punct_v    = 1'b0;
    punct_kind = KIND_LPAREN;

    if (!halt_q) begin
      case (mode_q)
        M_WORD, M_WORD_L: begin
          if (mode_q == M_WORD_L && is_quote) begin
            mode_d = M_STRING;
            qs_d   = (ch_i == "'");
            len_d  = '0;
            hits_d = '1;
          end else if (is_idc) begin
            hits_d = hits_q & add_match;
            len_d  = (len_q == '1) ? len_q : len_q + 1'b1;
            mode_d = M_WORD;
          end else begin
            kw_a     = 1'b1;
            run_idle = 1'b1;
            len_d    = '0;
            hits_d   = '1;
          end
        end
        M_SLASH: begin
          if (ch_i == "*")      mode_d = M_BLOCK;
          else if (ch_i == "/") mode_d = M_LINE;
          else                  run_idle = 1'b1;
        end
        M_BLOCK: begin
          if (ch_i == "*") mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (ch_i == "/")      mode_d = M_IDLE;
          else if (ch_i != "*") mode_d = M_BLOCK;
        end
        M_LINE, M_PREPROC: begin
          if (is_nl) mode_d = M_IDLE;
        end
        M_STRING: begin
          if (ch_i == (qs_q ? 8'h27 : 8'h22)) mode_d = M_IDLE;
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        mode_d = M_IDLE;
        if (ch_i == 8'h00) begin
          halt_d = 1'b1;
        end else if (is_ws) begin
          mode_d = M_IDLE;
        end else if (ch_i == "/") begin
          mode_d = M_SLASH;
        end else if (ch_i == "#") begin
          mode_d = M_PREPROC;
        end else if (is_quote) begin
          mode_d = M_STRING;
          qs_d   = (ch_i == "'");
        end else if (is_idc) begin
          wpos_d     = pos_q;
          wline_d    = line_q;
          wcol_d     = col_q;
          len_d      = 4'd1;
          hits_d     = add_match;
          mode_d     = (ch_i == "L") ? M_WORD_L : M_WORD;
        end else begin
          punct_v = 1'b1;
          case (ch_i)
            "(":     punct_kind = KIND_LPAREN;
            ")":     punct_kind = KIND_RPAREN;
            "{":     punct_kind = KIND_LBRACE;
            "}":     punct_kind = KIND_RBRACE;
            ";":     punct_kind = KIND_SEMI;
            ":":     punct_kind = KIND_COLON;
            default: punct_v    = 1'b0;
          endcase
        end
      end
    end
  end

  // Word end: either ended by this byte (old word) or flushed by the final byte
  always_comb begin
    flush    = last_i && !halt_d && (mode_d == M_WORD || mode_d == M_WORD_L);
    sel_len  = kw_a ? len_q : len_d;
    sel_hits = kw_a ? hits_q : hits_d;
    kw_v     = 1'b0;
    kw_kind  = KIND_CONTINUE;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (sel_hits[k] && kw_len(kind_e'(KindW'(k))) == sel_len) begin
        kw_v    = kw_a || flush;
        kw_kind = kind_e'(KindW'(k));
      end
    end
  end

  always_comb begin
    cnt1 = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    cnt2 = (cnt1 == '1) ? cnt1 : cnt1 + 1'b1;

    kw_tok.kind = kw_kind;
    kw_tok.pos  = kw_a ? wpos_q : wpos_d;
    kw_tok.len  = sel_len;
    kw_tok.line = kw_a ? wline_q : wline_d;
    kw_tok.col  = kw_a ? wcol_q : wcol_d;
    kw_tok.num  = cnt_q;
    kw_tok.eob  = !punct_v;

    p_tok.kind = punct_kind;
    p_tok.pos  = pos_q;
    p_tok.len  = 4'd1;
    p_tok.line = line_q;
    p_tok.col  = col_q;
    p_tok.num  = kw_v ? cnt1 : cnt_q;
    p_tok.eob  = 1'b1;

    ent.two = kw_v && punct_v;
    ent.t0  = kw_v ? kw_tok : p_tok;
    ent.t1  = p_tok;
  end

  assign push_o      = accept_i && (kw_v || punct_v);
  assign push_data_o = ent;

  always_comb begin
    pos_d  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
    line_d = (is_nl && line_q != '1) ? line_q + 1'b1 : line_q;
    col_d  = is_nl ? COLUMN_WIDTH'(1) : ((col_q == '1) ? col_q : col_q + 1'b1);
    cnt_d  = (kw_v && punct_v) ? cnt2 : ((kw_v || punct_v) ? cnt1 : cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      qs_q    <= 1'b0;
      len_q   <= '0;
      hits_q  <= '1;
      pos_q   <= '0;
      line_q  <= LINE_WIDTH'(1);
      col_q   <= COLUMN_WIDTH'(1);
      wpos_q  <= '0;
      wline_q <= LINE_WIDTH'(1);
      wcol_q  <= COLUMN_WIDTH'(1);
      halt_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        // final byte: drop all scan state back to its start values
        mode_q  <= M_IDLE;
        qs_q    <= 1'b0;
        len_q   <= '0;
        hits_q  <= '1;
        pos_q   <= '0;
        line_q  <= LINE_WIDTH'(1);
        col_q   <= COLUMN_WIDTH'(1);
        wpos_q  <= '0;
        wline_q <= LINE_WIDTH'(1);
        wcol_q  <= COLUMN_WIDTH'(1);
        halt_q  <= 1'b0;
        cnt_q   <= '0;
      end else begin
        mode_q  <= mode_d;
        qs_q    <= qs_d;
        len_q   <= len_d;
        hits_q  <= hits_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
        col_q   <= col_d;
        wpos_q  <= wpos_d;
        wline_q <= wline_d;
        wcol_q  <= wcol_d;
        halt_q  <= halt_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/klx_queue.sv =====
// Small register queue between the scanner front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module klx_queue import klx_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QueueDepthDef,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW  = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      pop_data_o,
  output logic                   empty_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wr_q, rd_q;
  logic [CNTW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CNTW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count lost a write");

endmodule

`default_nettype wire

// ===== src/klx_back.sv =====
// Output stage: splits queued bursts into single tokens behind a result register.
`timescale 1ns / 1ps
`default_nettype none

module klx_back import klx_pkg::*; #(
  parameter int POSITION_WIDTH = PositionWidthDef,
  parameter int LINE_WIDTH     = LineWidthDef,
  parameter int COLUMN_WIDTH   = ColumnWidthDef,
  localparam int TokW          = tok_bits(POSITION_WIDTH, LINE_WIDTH, COLUMN_WIDTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      empty_i,
  input  wire logic [2*TokW:0]           head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [KindW-1:0]               kind_o,
  output logic [POSITION_WIDTH-1:0]      start_pos_o,
  output logic [LenW-1:0]                tok_length_o,
  output logic [LINE_WIDTH-1:0]          line_o,
  output logic [COLUMN_WIDTH-1:0]        column_o,
  output logic [TokNumW-1:0]             token_number_o,
  output logic                           end_of_burst_o
);

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic [POSITION_WIDTH-1:0] pos;
    logic [LenW-1:0]           len;
    logic [LINE_WIDTH-1:0]     line;
    logic [COLUMN_WIDTH-1:0]   col;
    logic [TokNumW-1:0]        num;
    logic                      eob;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } entry_t;

  entry_t head;
  logic   ov_q, pend_q;
  tok_t   otok_q, ptok_q;
  logic   out_free;

  assign head     = head_i;
  assign out_free = !ov_q || !out_stall_i;
  assign pop_o    = out_free && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        ov_q   <= 1'b1;
        pend_q <= 1'b0;
      end else begin
        ov_q   <= !empty_i;
        pend_q <= !empty_i && head.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        otok_q <= ptok_q;
      end else if (!empty_i) begin
        otok_q <= head.t0;
        ptok_q <= head.t1;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = otok_q.kind;
  assign start_pos_o    = otok_q.pos;
  assign tok_length_o   = otok_q.len;
  assign line_o         = otok_q.line;
  assign column_o       = otok_q.col;
  assign token_number_o = otok_q.num;
  assign end_of_burst_o = otok_q.eob;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ov_q) else $error("second token pending without a first on the output");

endmodule

`default_nettype wire

// ===== src/keyword_punct_lexer.sv =====
// Top level of the keyword/punctuation lexer: front end, token queue and output stage.
// Throughput: one source byte per cycle while the token queue has room; a byte that
//   yields two tokens puts them out in turn; the token queue (QUEUE_DEPTH bursts) absorbs
//   the difference. A burst is written to the queue, then registered by the output stage.
//   The second token of a pair waits in the output stage behind the first.
// Reset: rst_ni is asynchronous and active low; it returns the scanner to between tokens
//   with position 0, line 1, column 1, token count 0, and empties the queue.
// The final byte of a source (last_i) flushes a pending word and restores that state.
`timescale 1ns / 1ps
`default_nettype none

module keyword_punct_lexer import klx_pkg::*; #(
  parameter int POSITION_WIDTH = PositionWidthDef,
  parameter int LINE_WIDTH     = LineWidthDef,
  parameter int COLUMN_WIDTH   = ColumnWidthDef,
  parameter int QUEUE_DEPTH    = QueueDepthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // source bytes
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      last_i,
  // tokens
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [KindW-1:0]               kind_o,
  output logic [POSITION_WIDTH-1:0]      start_pos_o,
  output logic [LenW-1:0]                tok_length_o,
  output logic [LINE_WIDTH-1:0]          line_o,
  output logic [COLUMN_WIDTH-1:0]        column_o,
  output logic [TokNumW-1:0]             token_number_o,
  output logic                           end_of_burst_o
);

  localparam int TokW = tok_bits(POSITION_WIDTH, LINE_WIDTH, COLUMN_WIDTH);

  logic              in_xfer;
  logic              push, pop, q_full, q_empty;
  logic [2*TokW:0]   push_data, head_data;

  // Hold the source only when the queue has no room for this byte's burst
  assign in_stall_o = q_full;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Front end: classify each byte, track scan state and positions, build the
  // burst of zero, one or two tokens (keyword first, then punctuation)
  klx_front #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LINE_WIDTH     (LINE_WIDTH),
    .COLUMN_WIDTH   (COLUMN_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Bursts wait here so the scanner keeps running while the sink stalls
  klx_queue #(
    .DATA_W (2*TokW + 1),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (head_data),
    .empty_o     (q_empty)
  );

  // Output stage: one token per transfer from a registered result
  klx_back #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LINE_WIDTH     (LINE_WIDTH),
    .COLUMN_WIDTH   (COLUMN_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (head_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .start_pos_o    (start_pos_o),
    .tok_length_o   (tok_length_o),
    .line_o         (line_o),
    .column_o       (column_o),
    .token_number_o (token_number_o),
    .end_of_burst_o (end_of_burst_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/keyword_punct_lexer_checker.sv =====
// Token checker for the keyword/punctuation lexer: predicts tokens from accepted bytes.
`timescale 1ns / 1ps

module keyword_punct_lexer_checker import klx_pkg::*; #(
  parameter int POSITION_WIDTH = PositionWidthDef,
  parameter int LINE_WIDTH     = LineWidthDef,
  parameter int COLUMN_WIDTH   = ColumnWidthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      last_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic [KindW-1:0]          kind_i,
  input  wire logic [POSITION_WIDTH-1:0] start_pos_i,
  input  wire logic [LenW-1:0]           tok_length_i,
  input  wire logic [LINE_WIDTH-1:0]     line_i,
  input  wire logic [COLUMN_WIDTH-1:0]   column_i,
  input  wire logic [TokNumW-1:0]        token_number_i,
  input  wire logic                      end_of_burst_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    tokens_pending_o
);

  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_WORD_L,
    SCAN_SLASH,
    SCAN_BLOCK,
    SCAN_BLOCK_STAR,
    SCAN_LINE,
    SCAN_PREPROC,
    SCAN_STRING
  } scan_mode_e;

  typedef struct packed {
    kind_e                     kind;
    logic [POSITION_WIDTH-1:0] start_pos;
    logic [LenW-1:0]           tok_length;
    logic [LINE_WIDTH-1:0]     line;
    logic [COLUMN_WIDTH-1:0]   column;
    logic [TokNumW-1:0]        token_number;
    logic                      end_of_burst;
  } token_t;

  scan_mode_e                scan_mode;
  logic                      quote_single;
  logic [LenW-1:0]           word_len;
  logic [NumKw-1:0]          kw_hits;
  logic [POSITION_WIDTH-1:0] byte_pos, word_pos;
  logic [LINE_WIDTH-1:0]     cur_line, word_line;
  logic [COLUMN_WIDTH-1:0]   cur_col, word_col;
  logic                      halted;
  logic [TokNumW-1:0]        tok_count;

  token_t      byte_tokens[$];
  token_t      expected_tokens[$];
  int unsigned fail_total = 0;

  function automatic string keyword_text(input int k);
    string s;
    case (k)
      0:       s = "continue";
      1:       s = "for";
      2:       s = "do";
      3:       s = "while";
      4:       s = "namespace";
      5:       s = "struct";
      default: s = "class";
    endcase
    return s;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic reset_scanner();
    scan_mode    = SCAN_IDLE;
    quote_single = 1'b0;
    word_len     = '0;
    kw_hits      = '1;
    byte_pos     = '0;
    cur_line     = LINE_WIDTH'(1);
    cur_col      = COLUMN_WIDTH'(1);
    word_pos     = '0;
    word_line    = LINE_WIDTH'(1);
    word_col     = COLUMN_WIDTH'(1);
    halted       = 1'b0;
    tok_count    = '0;
  endtask

  task automatic queue_token(input kind_e k, input logic [POSITION_WIDTH-1:0] pos,
                             input logic [LenW-1:0] len, input logic [LINE_WIDTH-1:0] ln,
                             input logic [COLUMN_WIDTH-1:0] cl);
    token_t t;
    if (byte_tokens.size() < 2) begin
      t.kind         = k;
      t.start_pos    = pos;
      t.tok_length   = len;
      t.line         = ln;
      t.column       = cl;
      t.token_number = tok_count;
      t.end_of_burst = 1'b0;
      byte_tokens.push_back(t);
      if (tok_count != '1) tok_count++;
    end
  endtask

  // Drop every keyword whose next letter differs from c.
  task automatic add_word_char(input logic [7:0] c);
    string kw;
    for (int k = 0; k < NumKw; k++) begin
      kw = keyword_text(k);
      if (!(word_len < kw.len() && kw[word_len] == c)) kw_hits[k] = 1'b0;
    end
    if (word_len != 4'd15) word_len++;
  endtask

  task automatic close_word();
    string kw;
    logic  found;
    found = 1'b0;
    for (int k = 0; k < NumKw; k++) begin
      kw = keyword_text(k);
      if (!found && kw_hits[k] && kw.len() == word_len) begin
        queue_token(kind_e'(k), word_pos, word_len, word_line, word_col);
        found = 1'b1;
      end
    end
    scan_mode = SCAN_IDLE;
    word_len  = '0;
    kw_hits   = '1;
  endtask

  task automatic scan_from_idle(input logic [7:0] c);
    string puncts;
    puncts    = "(){};:";
    scan_mode = SCAN_IDLE;
    if (c == 8'h00) begin
      halted = 1'b1;
    end else if (!is_blank(c)) begin
      if (c == "/") begin
        scan_mode = SCAN_SLASH;
      end else if (c == "#") begin
        scan_mode = SCAN_PREPROC;
      end else if (c == "\"" || c == "'") begin
        scan_mode    = SCAN_STRING;
        quote_single = (c == "'");
      end else if (is_word_char(c)) begin
        word_pos  = byte_pos;
        word_line = cur_line;
        word_col  = cur_col;
        word_len  = '0;
        kw_hits   = '1;
        add_word_char(c);
        scan_mode = (c == "L") ? SCAN_WORD_L : SCAN_WORD;
      end else begin
        for (int p = 0; p < 6; p++)
          if (c == puncts[p])
            queue_token(kind_e'(int'(KIND_LPAREN) + p), byte_pos, 4'd1, cur_line, cur_col);
      end
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic fin);
    token_t t;
    byte_tokens.delete();
    if (!halted) begin
      case (scan_mode)
        SCAN_WORD, SCAN_WORD_L: begin
          if (scan_mode == SCAN_WORD_L && (c == "\"" || c == "'")) begin
            scan_mode    = SCAN_STRING;
            quote_single = (c == "'");
            word_len     = '0;
            kw_hits      = '1;
          end else if (is_word_char(c)) begin
            add_word_char(c);
            scan_mode = SCAN_WORD;
          end else begin
            close_word();
            scan_from_idle(c);
          end
        end
        SCAN_SLASH: begin
          if (c == "*") scan_mode = SCAN_BLOCK;
          else if (c == "/") scan_mode = SCAN_LINE;
          else scan_from_idle(c);
        end
        SCAN_BLOCK: begin
          if (c == "*") scan_mode = SCAN_BLOCK_STAR;
        end
        SCAN_BLOCK_STAR: begin
          if (c == "/") scan_mode = SCAN_IDLE;
          else if (c != "*") scan_mode = SCAN_BLOCK;
        end
        SCAN_LINE, SCAN_PREPROC: begin
          if (c == "\n") scan_mode = SCAN_IDLE;
        end
        SCAN_STRING: begin
          if (c == (quote_single ? 8'h27 : 8'h22)) scan_mode = SCAN_IDLE;
        end
        default: scan_from_idle(c);
      endcase
      if (fin && !halted && (scan_mode == SCAN_WORD || scan_mode == SCAN_WORD_L)) close_word();
    end
    if (c == "\n") begin
      if (cur_line != '1) cur_line++;
      cur_col = COLUMN_WIDTH'(1);
    end else if (cur_col != '1) begin
      cur_col++;
    end
    if (byte_pos != '1) byte_pos++;
    for (int i = 0; i < byte_tokens.size(); i++) begin
      t              = byte_tokens[i];
      t.end_of_burst = (i == byte_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
    if (fin) reset_scanner();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("token kind %0d at start_pos %0d with nothing expected", kind_i, start_pos_i);
      fail_total++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("kind", want.kind, kind_i);
      check_field("start_pos", want.start_pos, start_pos_i);
      check_field("tok_length", want.tok_length, tok_length_i);
      check_field("line", want.line, line_i);
      check_field("column", want.column, column_i);
      check_field("token_number", want.token_number, token_number_i);
      check_field("end_of_burst", want.end_of_burst, end_of_burst_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scanner();
      expected_tokens.delete();
      tokens_pending_o <= 0;
      fail_count_o     <= fail_total;
    end else begin
      if (in_valid_i && !in_stall_i) lex_byte(ch_i, last_i);
      if (out_valid_i && !out_stall_i) check_token();
      tokens_pending_o <= expected_tokens.size();
      fail_count_o     <= fail_total;
    end
  end

endmodule

// ===== tb/sv/keyword_punct_lexer_tb.sv =====
// Testbench top for the keyword/punctuation lexer: source stimulus, stall pattern, verdict.
`timescale 1ns / 1ps

module keyword_punct_lexer_tb;
  import klx_pkg::*;

  localparam int PosW  = PositionWidthDef;
  localparam int LineW = LineWidthDef;
  localparam int ColW  = ColumnWidthDef;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic [7:0] src_ch = 8'h00;
  logic src_last  = 1'b0;
  logic out_stall = 1'b0;

  wire logic               in_stall;
  wire logic               out_valid;
  wire logic [KindW-1:0]   kind;
  wire logic [PosW-1:0]    start_pos;
  wire logic [LenW-1:0]    tok_length;
  wire logic [LineW-1:0]   tok_line;
  wire logic [ColW-1:0]    tok_column;
  wire logic [TokNumW-1:0] token_number;
  wire logic               end_of_burst;

  int unsigned fail_count;
  int unsigned tokens_pending;

  keyword_punct_lexer #(
    .POSITION_WIDTH(PosW),
    .LINE_WIDTH    (LineW),
    .COLUMN_WIDTH  (ColW)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .ch_i          (src_ch),
    .last_i        (src_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .start_pos_o   (start_pos),
    .tok_length_o  (tok_length),
    .line_o        (tok_line),
    .column_o      (tok_column),
    .token_number_o(token_number),
    .end_of_burst_o(end_of_burst)
  );

  // The checker sees both channels beside the DUT and keeps the expected-token queue.
  keyword_punct_lexer_checker #(
    .POSITION_WIDTH(PosW),
    .LINE_WIDTH    (LineW),
    .COLUMN_WIDTH  (ColW)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .ch_i            (src_ch),
    .last_i          (src_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .start_pos_i     (start_pos),
    .tok_length_i    (tok_length),
    .line_i          (tok_line),
    .column_i        (tok_column),
    .token_number_i  (token_number),
    .end_of_burst_i  (end_of_burst),
    .fail_count_o    (fail_count),
    .tokens_pending_o(tokens_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far above the slowest legal run under the heaviest stalling.
  initial begin
    #1_000_000;
    $display("keyword_punct_lexer_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: each time the stall_left countdown runs out, pick a new stall style - never stall, light
  // stalling, heavy stalling, or alternate every cycle. The never-stall style
  // leaves stretches where the token output runs at full rate.
  // ---------------------------------------------------------------------------
  int unsigned stall_left  = 0;
  int unsigned stall_style = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left  = $urandom_range(16, 128);
      end else begin
        stall_left--;
      end
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bytes go out in bursts of 1..24 transfers. Most bursts are preceded
  // by a gap with valid low; a quarter follow the previous burst directly,
  // so valid also stays high across burst boundaries.
  // ---------------------------------------------------------------------------
  logic [7:0]  src_bytes[$];
  int unsigned burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    src_ch   <= b;
    src_last <= fin;
    // Hold the payload until the edge that takes the transfer.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Send the collected source, marking its final byte, and clear it.
  task automatic send_source();
    for (int i = 0; i < src_bytes.size(); i++) send_byte(src_bytes[i], i == src_bytes.size() - 1);
    src_bytes.delete();
  endtask

  task automatic put_byte(input logic [7:0] b);
    src_bytes.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endtask

  function automatic string keyword_word(input int k);
    string s;
    case (k)
      0:       s = "continue";
      1:       s = "for";
      2:       s = "do";
      3:       s = "while";
      4:       s = "namespace";
      5:       s = "struct";
      default: s = "class";
    endcase
    return s;
  endfunction

  // Pick one character out of a set.
  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Identifier characters biased toward keyword letters and the string prefix.
  function automatic logic [7:0] word_char();
    return pick_char("abcdefhilmnorstuwxyzL_059CFQ");
  endfunction

  // ---------------------------------------------------------------------------
  // Random fragments. Keywords, near-keywords and punctuation dominate so that
  // tokens are frequent; comments, preprocessor lines and strings come with
  // random content; raw noise bytes and the odd NUL break things up.
  // ---------------------------------------------------------------------------
  task automatic put_fragment();
    string       kw;
    int unsigned pick, n, pos;
    logic [7:0]  q;
    pick = $urandom_range(0, 39);
    if (pick < 12) begin
      put_text(keyword_word($urandom_range(0, NumKw - 1)));
    end else if (pick < 16) begin
      // Near miss: truncated, extended or with one letter replaced.
      kw = keyword_word($urandom_range(0, NumKw - 1));
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < kw.len() - 1; i++) put_byte(kw[i]);
        1: begin
          put_text(kw);
          put_byte(word_char());
        end
        default: begin
          pos = $urandom_range(0, kw.len() - 1);
          for (int i = 0; i < kw.len(); i++) put_byte(i == pos ? word_char() : kw[i]);
        end
      endcase
    end else if (pick < 19) begin
      n = $urandom_range(1, 18);
      repeat (n) put_byte(word_char());
    end else if (pick < 26) begin
      put_byte(pick_char("(){};:"));
    end else if (pick < 29) begin
      put_byte(($urandom_range(0, 2) == 0) ? 8'h20 : 8'(($urandom_range(9, 13))));
    end else if (pick < 31) begin
      put_text("/*");
      n = $urandom_range(0, 6);
      repeat (n) put_byte(($urandom_range(0, 9) == 0) ? 8'h00 : pick_char("ab*/ \n(;"));
      put_text("*/");
    end else if (pick < 33) begin
      // Line comment or preprocessor line with arbitrary bytes up to the newline.
      put_text(($urandom_range(0, 1) == 0) ? "//" : "#");
      n = $urandom_range(0, 8);
      repeat (n) begin
        q = 8'($urandom_range(0, 255));
        put_byte(q == 8'h0a ? 8'h20 : q);
      end
      put_byte(8'h0a);
    end else if (pick < 35) begin
      if ($urandom_range(0, 1) == 0) put_byte("L");
      q = ($urandom_range(0, 1) == 0) ? 8'h22 : 8'h27;
      put_byte(q);
      n = $urandom_range(0, 5);
      repeat (n) put_byte(pick_char({"ab (;{/*\n", (q == 8'h22) ? "'" : "\""}));
      put_byte(q);
    end else if (pick < 37) begin
      put_byte(8'($urandom_range(0, 255)));
    end else if (pick < 39) begin
      put_byte("/");
    end else begin
      put_byte(8'h00);
    end
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned frags;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every keyword and punctuation mark, keywords ended by punctuation (two
    // tokens from one byte), tab, vertical tab, form feed and carriage return,
    // and a word flushed by the final byte.
    put_text("for(while){do;}class:namespace");
    put_byte(8'h0b);
    put_text("struct");
    put_byte(8'h0c);
    put_byte(8'h0d);
    put_text("\tcontinue");
    send_source();

    // Lone slashes, block comments that only close at a later star-slash,
    // empty block comment, line comment and preprocessor line.
    put_text("a/b /x(/*for*/do/*/ ** */while/**/;//c{\n#if (\n}");
    send_source();

    // String prefix on strings and characters, a word that only starts with L,
    // and a string left open at the final byte.
    put_text("L\"for\"Lfor(L'(' 'x' \"do\" Lx\"while\"\"open for");
    send_source();

    // Words with digits and overlong words are not keywords; top byte value.
    put_text("continuecontinue;for1 do9( _for struc forx)");
    put_byte(8'hff);
    put_text("do");
    send_source();

    // NUL after a word halts the scan; the rest up to the final byte is ignored.
    put_text("do");
    put_byte(8'h00);
    put_text("for(");
    send_source();

    // NUL inside a comment is content; a NUL ending a keyword still emits it.
    put_text("/*");
    put_byte(8'h00);
    put_text("*/for");
    put_byte(8'h00);
    put_text("{");
    send_source();

    // Lone prefix letter as the whole source, NUL as the final byte, and an
    // unterminated block comment.
    put_text("L");
    send_source();
    put_text("{");
    put_byte(8'h00);
    send_source();
    put_text("/*open for");
    send_source();

    // Random sources of 1..30 fragments, separated by a blank half the time.
    random_bytes = 0;
    while (random_bytes < 500) begin
      frags = $urandom_range(1, 30);
      repeat (frags) begin
        put_fragment();
        if ($urandom_range(0, 1) == 0) put_byte(8'h20);
      end
      random_bytes += src_bytes.size();
      send_source();
    end
    in_valid <= 1'b0;

    // Let the checker's count take in the final transfer, then drain.
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("keyword_punct_lexer_tb OK");
    end else begin
      $display("keyword_punct_lexer_tb NOT OK");
    end
    $finish;
  end

endmodule
